### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication
`define AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic        command;
		logic [15:0] token;
		logic [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_token;
		logic [7:0]  out_priority;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0] token;
		logic [7:0]  prio;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

### rtl/core/stable_priority_queue_unit.sv
// A result beat is registered and appears in the cycle after its request beat
// is accepted. One insert or remove per cycle, held off while a result waits
// with rsp_ready low; the result register parts the two channels.
// Reset clears the fill count and the result valid; slot contents are left
// as they are and are never read before being written.
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Sorted-array priority queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue_unit #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic               acc;
	logic               full;
	logic               empty;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_d;
	spq_pkg::cell_ctl_t ctl;
	spq_pkg::entry_t    new_entry;
	spq_pkg::entry_t    ent [DEPTH];
	logic               aft [DEPTH];
	spq_pkg::rsp_t      rsp_d;
	spq_pkg::rsp_t      rsp_q;
	logic               rsp_valid_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign full      = cnt_q == CW'(DEPTH);
	assign empty     = cnt_q == '0;

	assign ctl.ins = acc && (req.command == spq_pkg::CMD_INSERT) && !full;
	assign ctl.rem = acc && (req.command == spq_pkg::CMD_REMOVE) && !empty;

	assign new_entry.token = req.token;
	assign new_entry.prio  = req.priority_req;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_a;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_a = 1'b0;
		end else begin : g_mid
			assign left_e = ent[i-1];
			assign left_a = aft[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = ent[i+1];
		end

		spq_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cnt        (cnt_q),
			.new_entry  (new_entry),
			.left_entry (left_e),
			.left_after (left_a),
			.right_entry(right_e),
			.entry      (ent[i]),
			.after      (aft[i])
		);
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ctl.ins) begin
			cnt_d = cnt_q + 1'b1;
		end else if (ctl.rem) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	always_comb begin
		rsp_d              = '0;
		rsp_d.occupancy    = 5'(cnt_d);
		if (req.command == spq_pkg::CMD_INSERT) begin
			rsp_d.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
		end else if (empty) begin
			rsp_d.status = spq_pkg::ST_EMPTY;
		end else begin
			rsp_d.status       = spq_pkg::ST_REMOVED;
			rsp_d.out_token    = ent[0].token;
			rsp_d.out_priority = ent[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: hold until the next accepted beat
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`AST_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH))
	`AST_NXT(a_ins_grows, ctl.ins, cnt_q == $past(cnt_q) + 1'b1)
	`AST_IMP(a_head_sorted, cnt_q >= CW'(2), ent[0].prio <= ent[1].prio)
	`AST_NXT(a_full_holds, acc && full && req.command == spq_pkg::CMD_INSERT,
		rsp.status == spq_pkg::ST_FULL && cnt_q == $past(cnt_q))

endmodule

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds, shifts towards the tail on insert,
// shifts towards the head on remove.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]     cnt,
	input  spq_pkg::entry_t   new_entry,
	input  spq_pkg::entry_t   left_entry,
	input  logic              left_after,
	input  spq_pkg::entry_t   right_entry,
	output spq_pkg::entry_t   entry,
	output logic              after
);

	spq_pkg::entry_t entry_q;
	logic            occ;

	assign occ   = cnt > CW'(IDX);
	// an empty slot, or one less urgent than the new entry, lies after it
	assign after = !occ || (entry_q.prio > new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (after && left_after) begin
				entry_q <= left_entry;
			end else if (after) begin
				entry_q <= new_entry;
			end
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule
